FILE: rtl/core/srt_pkg.sv
package srt_pkg;

  // Table geometry.
  localparam int unsigned DEPTH      = 16;
  localparam int unsigned NAME_BYTES = 20;

  // Counts run from 0 to DEPTH; indexes from 0 to DEPTH-1.
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(DEPTH);

  // Stream widths.
  localparam int unsigned IN_DATA_W  = 208;
  localparam int unsigned OUT_DATA_W = 224;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned STATUS_W   = 3;

  // Operation codes carried on the slave tuser.
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DUMP   = 2'd2;

  // Result codes carried on the master tuser.
  localparam logic [STATUS_W-1:0] STAT_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_DELETED   = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_LISTED    = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd5;

  // One stored record.
  typedef struct packed {
    logic signed [31:0] key;
    logic [15:0]        score;
    logic [63:0]        name_lo;
    logic [63:0]        name_mid;
    logic [31:0]        name_hi;
  } rec_t;

  // Command broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_ROTATE = 2'd3
  } cmd_e;

  // Where a cell sits relative to the current fill level.
  typedef struct packed {
    logic occ;      // cell holds a record
    logic at_fill;  // first free cell
    logic at_tail;  // last occupied cell
  } cell_pos_t;

  // Keeps the bytes of an 8-byte name word that lie below NAME_BYTES.
  function automatic logic [63:0] name_mask(input int unsigned base);
    logic [63:0] m;
    m = '0;
    for (int unsigned b = 0; b < 8; b++) begin
      if (base + b < NAME_BYTES) begin
        m[b*8 +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

FILE: rtl/core/srt_cell.sv
module srt_cell
  import srt_pkg::*;
(
  input  logic               clk_i,
  input  cmd_e               cmd_i,
  input  logic signed [31:0] op_key_i,
  input  rec_t               new_rec_i,
  input  cell_pos_t          pos_i,
  input  rec_t               left_rec_i,
  input  logic               left_ge_i,
  input  rec_t               right_rec_i,
  input  rec_t               head_rec_i,
  output rec_t               rec_o,
  output logic               ge_o,
  output logic               hit_o
);

  rec_t rec_q, rec_d;

  // Occupied cells at or after the operand's sorted place.
  assign ge_o  = pos_i.occ && (rec_q.key >= op_key_i);
  // First cell holding the operand key: equal keys are contiguous.
  assign hit_o = pos_i.occ && (rec_q.key == op_key_i) && !left_ge_i;

  always_comb begin
    rec_d = rec_q;
    case (cmd_i)
      CMD_INSERT: begin
        if (left_ge_i) begin
          rec_d = left_rec_i;
        end else if (ge_o || pos_i.at_fill) begin
          rec_d = new_rec_i;
        end
      end
      CMD_DELETE: begin
        if (ge_o) begin
          rec_d = right_rec_i;
        end
      end
      CMD_ROTATE: begin
        if (pos_i.at_tail) begin
          rec_d = head_rec_i;
        end else if (pos_i.occ) begin
          rec_d = right_rec_i;
        end
      end
      default: begin
        rec_d = rec_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o = rec_q;

endmodule

FILE: rtl/core/sorted_record_table.sv
// Sorted record table. Holds up to 16 records (signed 32-bit number, 16-bit
// score, 20-byte name) in ascending order of number inside a chain of cells,
// one record per cell. A transaction on the slave stream carries the
// operation in tuser: insert (0), delete by number (1) or dump (2); code 3 is
// dropped without any result. Insert and delete first capture the
// transaction, and then every cell compares its key against the operand in
// parallel and shifts toward its neighbor while the result is written to the
// output register. A dump first chooses between a listing and the empty
// result, then lists the records one per cycle while the output register is
// free, by rotating the occupied cells through the head cell. The dump leaves
// the table in its original order. An operation waits while the output
// register still holds an unaccepted result. Equal numbers sit newest
// first, and a delete removes the first of them. A full table drops an
// insert and reports it. A new transaction is accepted as soon as the
// previous operation has placed its last result in the output register, even
// while that result still waits on the master side. No clearing pass is
// needed after reset; only the fill count and the control state are
// reset, not the cells.
module sorted_record_table
  import srt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Slave stream.
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // tdata from bit 0: student_number[31:0], score[15:0], name_bytes_0_7[63:0],
  // name_bytes_8_15[63:0], name_bytes_16_19[31:0].
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // tuser: kind[1:0].
  input  logic [KIND_W-1:0]     s_axis_tuser_i,
  // Master stream.
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // tdata from bit 0: out_number[31:0], out_score[15:0], out_name_0_7[63:0],
  // out_name_8_15[63:0], out_name_16_19[31:0], position[4:0],
  // entries_held[4:0], zero fill.
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // tuser: status[2:0].
  output logic [STATUS_W-1:0]   m_axis_tuser_o,
  // tlast: last result of the transaction.
  output logic                  m_axis_tlast_o
);

  localparam logic [63:0] MASK_LO  = name_mask(0);
  localparam logic [63:0] MASK_MID = name_mask(8);
  localparam logic [63:0] MASK_HI  = name_mask(16);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_DUMP = 3'b100
  } state_e;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    rec_t                rec;
    logic [CNT_W-1:0]    position;
    logic [CNT_W-1:0]    entries;
    logic                last;
  } result_t;

  state_e state_q, state_d;

  // Captured transaction.
  logic [KIND_W-1:0] kind_q;
  rec_t              op_q;

  logic [CNT_W-1:0] fill_q, fill_d;
  logic [IDX_W-1:0] dcnt_q, dcnt_d;

  logic    out_valid_q, out_valid_d;
  result_t out_q, out_d;

  // Cell chain.
  cmd_e      cmd;
  rec_t      recs  [DEPTH];
  logic      ge    [DEPTH];
  logic      hit   [DEPTH];
  cell_pos_t cpos  [DEPTH];

  logic [DEPTH-1:0] lt_vec;
  logic [DEPTH-1:0] hit_vec;
  logic [CNT_W-1:0] sort_pos;
  logic             found;
  rec_t             hit_rec;
  logic             slot_free;
  logic             in_fire;
  logic             full;

  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign slot_free = !out_valid_q || m_axis_tready_i;
  assign full      = (fill_q >= CNT_W'(DEPTH));

  assign s_axis_tready_o = (state_q == ST_IDLE);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    rec_t left_rec, right_rec;
    logic left_ge;

    assign cpos[i].occ     = (CNT_W'(i) < fill_q);
    assign cpos[i].at_fill = (CNT_W'(i) == fill_q);
    assign cpos[i].at_tail = (CNT_W'(i + 1) == fill_q);

    if (i == 0) begin : g_first
      assign left_rec = '0;
      assign left_ge  = 1'b0;
    end else begin : g_inner_l
      assign left_rec = recs[i-1];
      assign left_ge  = ge[i-1];
    end

    if (i == DEPTH - 1) begin : g_final
      assign right_rec = recs[i];
    end else begin : g_inner_r
      assign right_rec = recs[i+1];
    end

    srt_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .op_key_i    (op_q.key),
      .new_rec_i   (op_q),
      .pos_i       (cpos[i]),
      .left_rec_i  (left_rec),
      .left_ge_i   (left_ge),
      .right_rec_i (right_rec),
      .head_rec_i  (recs[0]),
      .rec_o       (recs[i]),
      .ge_o        (ge[i]),
      .hit_o       (hit[i])
    );

    assign lt_vec[i]  = cpos[i].occ && !ge[i];
    assign hit_vec[i] = hit[i];
  end

  // The occupied cells below the operand's place form a prefix, so their
  // count is the sorted index.
  assign sort_pos = CNT_W'($countones(lt_vec));
  assign found    = |hit_vec;

  // At most one cell reports a hit, so an OR of the gated records selects it.
  always_comb begin
    hit_rec = '0;
    for (int unsigned i = 0; i < DEPTH; i++) begin
      if (hit_vec[i]) begin
        hit_rec = hit_rec | recs[i];
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    dcnt_d      = dcnt_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_d       = out_q;
    cmd         = CMD_HOLD;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (kind_q)
          KIND_INSERT: begin
            if (slot_free) begin
              out_valid_d         = 1'b1;
              out_d               = '0;
              out_d.rec.key       = op_q.key;
              out_d.position      = sort_pos;
              out_d.last          = 1'b1;
              if (full) begin
                out_d.status  = STAT_FULL;
                out_d.entries = fill_q;
              end else begin
                cmd           = CMD_INSERT;
                fill_d        = fill_q + CNT_W'(1);
                out_d.status  = STAT_INSERTED;
                out_d.entries = fill_q + CNT_W'(1);
              end
              state_d = ST_IDLE;
            end
          end
          KIND_DELETE: begin
            if (slot_free) begin
              out_valid_d   = 1'b1;
              out_d         = '0;
              out_d.rec.key = op_q.key;
              out_d.last    = 1'b1;
              if (found) begin
                cmd            = CMD_DELETE;
                fill_d         = fill_q - CNT_W'(1);
                out_d.status   = STAT_DELETED;
                out_d.rec      = hit_rec;
                out_d.position = sort_pos;
                out_d.entries  = fill_q - CNT_W'(1);
              end else begin
                out_d.status  = STAT_NOT_FOUND;
                out_d.entries = fill_q;
              end
              state_d = ST_IDLE;
            end
          end
          KIND_DUMP: begin
            if (fill_q != '0) begin
              dcnt_d  = '0;
              state_d = ST_DUMP;
            end else if (slot_free) begin
              out_valid_d  = 1'b1;
              out_d        = '0;
              out_d.status = STAT_EMPTY;
              out_d.last   = 1'b1;
              state_d      = ST_IDLE;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_DUMP: begin
        if (slot_free) begin
          cmd            = CMD_ROTATE;
          out_valid_d    = 1'b1;
          out_d.status   = STAT_LISTED;
          out_d.rec      = recs[0];
          out_d.position = CNT_W'(dcnt_q);
          out_d.entries  = fill_q;
          out_d.last     = (CNT_W'(dcnt_q) + CNT_W'(1) == fill_q);
          dcnt_d         = dcnt_q + IDX_W'(1);
          if (out_d.last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      dcnt_q      <= dcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers; name bytes past the configured length are stored as zero.
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (in_fire) begin
      kind_q           <= s_axis_tuser_i;
      op_q.key         <= s_axis_tdata_i[31:0];
      op_q.score       <= s_axis_tdata_i[47:32];
      op_q.name_lo     <= s_axis_tdata_i[111:48] & MASK_LO;
      op_q.name_mid    <= s_axis_tdata_i[175:112] & MASK_MID;
      op_q.name_hi     <= s_axis_tdata_i[207:176] & MASK_HI[31:0];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tlast_o  = out_q.last;
  assign m_axis_tdata_o  = {
    {(OUT_DATA_W - 208 - 2 * CNT_W){1'b0}},
    out_q.entries,
    out_q.position,
    out_q.rec.name_hi,
    out_q.rec.name_mid,
    out_q.rec.name_lo,
    out_q.rec.score,
    out_q.rec.key
  };

`ifndef SYNTHESIS
  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(DEPTH))
    else $error("fill count above table depth");

  a_insert_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd == CMD_INSERT) |=> (fill_q == $past(fill_q) + CNT_W'(1)))
    else $error("insert did not grow the table by one");

  a_dump_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUMP) |-> (fill_q != '0 && CNT_W'(dcnt_q) < fill_q))
    else $error("dump running past the stored records");

  a_dump_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUMP && cmd == CMD_ROTATE && out_d.last) |=> (state_q == ST_IDLE))
    else $error("dump did not return to idle after its last record");
`endif

endmodule

FILE: tb/tb_sorted_record_table.sv
`timescale 1ns / 100ps

// Self-checking bench for the sorted record table.
//
// An initial block fills a queue of pending table operations. A clocked
// driver offers them on the slave stream, and a clocked receiver drives the
// master tready. On every accepted slave transaction, a model of the table
// inside this module works out the results the block must return and
// appends them to a queue. On every accepted master transaction, the oldest
// expected result is removed and compared field by field. Inputs change on
// the falling edge, and everything is sampled on the rising edge.
module tb_sorted_record_table;
  import srt_pkg::*;

  // Code 3 on the slave tuser is not an operation; the block drops it.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // One operation as it travels on the slave stream.
  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic signed [31:0] number;
    logic [15:0]        score;
    logic [63:0]        name_lo;
    logic [63:0]        name_mid;
    logic [31:0]        name_hi;
  } table_op_t;

  // One result as it travels on the master stream.
  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [31:0]         number;
    logic [15:0]         score;
    logic [63:0]         name_lo;
    logic [63:0]         name_mid;
    logic [31:0]         name_hi;
    logic [4:0]          position;
    logic [4:0]          held;
    logic                last;
  } table_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [KIND_W-1:0]     s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0]   m_tuser;
  logic                  m_tlast;

  sorted_record_table u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Stimulus and scoreboard state.
  table_op_t     pending_ops[$];
  table_result_t expected_results[$];
  table_op_t     cur_op;
  int unsigned   queued_count = 0;
  int unsigned   accepted_count = 0;
  int unsigned   error_count = 0;
  bit            op_taken = 1'b0;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_idle_pct = 0;
  int unsigned   hold_request = 0;
  int unsigned   hold_left = 0;
  logic signed [31:0] key_pool[16];

  // Model of the table contents: records in ascending key order.
  rec_t        model_recs[DEPTH];
  int unsigned model_fill = 0;

  // Works out the results of one accepted operation and updates the model.
  task automatic apply_table_op(input table_op_t op);
    table_result_t r;
    rec_t          nr;
    logic [159:0]  name;
    int unsigned   pos;
    int            i;
    int            b;
    bit            found;
    r = '{default: '0};
    r.last = 1'b1;
    case (op.kind)
      KIND_INSERT: begin
        // The new record goes in front of the first key that is not smaller,
        // so equal keys end up newest first.
        pos = model_fill;
        for (i = 0; i < model_fill; i++) begin
          if (model_recs[i].key >= op.number) begin
            pos = i;
            break;
          end
        end
        r.number = op.number;
        r.position = 5'(pos);
        if (model_fill >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          // Name bytes at or beyond the name length are stored as zero.
          name = {op.name_hi, op.name_mid, op.name_lo};
          for (b = NAME_BYTES; b < 20; b++) begin
            name[b*8 +: 8] = 8'h00;
          end
          nr.key = op.number;
          nr.score = op.score;
          nr.name_lo = name[63:0];
          nr.name_mid = name[127:64];
          nr.name_hi = name[159:128];
          for (i = model_fill; i > pos; i--) begin
            model_recs[i] = model_recs[i-1];
          end
          model_recs[pos] = nr;
          model_fill++;
          r.status = STAT_INSERTED;
        end
        r.held = 5'(model_fill);
        expected_results.push_back(r);
      end
      KIND_DELETE: begin
        found = 1'b0;
        r.number = op.number;
        for (i = 0; i < model_fill && !found; i++) begin
          if (model_recs[i].key == op.number) begin
            found = 1'b1;
            r.status = STAT_DELETED;
            r.score = model_recs[i].score;
            r.name_lo = model_recs[i].name_lo;
            r.name_mid = model_recs[i].name_mid;
            r.name_hi = model_recs[i].name_hi;
            r.position = 5'(i);
            for (b = i; b + 1 < model_fill; b++) begin
              model_recs[b] = model_recs[b+1];
            end
            model_fill--;
          end
        end
        if (!found) begin
          r.status = STAT_NOT_FOUND;
        end
        r.held = 5'(model_fill);
        expected_results.push_back(r);
      end
      KIND_DUMP: begin
        if (model_fill == 0) begin
          r.status = STAT_EMPTY;
          expected_results.push_back(r);
        end else begin
          for (i = 0; i < model_fill; i++) begin
            r.status = STAT_LISTED;
            r.number = model_recs[i].key;
            r.score = model_recs[i].score;
            r.name_lo = model_recs[i].name_lo;
            r.name_mid = model_recs[i].name_mid;
            r.name_hi = model_recs[i].name_hi;
            r.position = 5'(i);
            r.held = 5'(model_fill);
            r.last = (i + 1 == model_fill);
            expected_results.push_back(r);
          end
        end
      end
      default: begin
        // The unused code leaves the table alone and yields nothing.
      end
    endcase
  endtask

  task automatic check_field(input string fname, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
      error_count++;
    end
  endtask

  // Driver: a new operation is offered once the previous one was accepted.
  always @(negedge clk_i) begin
    if (rst_ni && (!s_tvalid || op_taken)) begin
      op_taken = 1'b0;
      if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_op = pending_ops.pop_front();
        s_tdata <= {cur_op.name_hi, cur_op.name_mid, cur_op.name_lo, cur_op.score,
                    cur_op.number};
        s_tuser <= cur_op.kind;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor. Results are checked before the model sees a new operation;
  // no result can leave the block in the cycle its operation is accepted.
  always @(posedge clk_i) begin
    table_result_t want;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected, status %0d, actual data %0h",
                   $time, m_tuser, m_tdata);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, m_tuser);
          check_field("out_number", want.number, m_tdata[31:0]);
          check_field("out_score", want.score, m_tdata[47:32]);
          check_field("out_name_0_7", want.name_lo, m_tdata[111:48]);
          check_field("out_name_8_15", want.name_mid, m_tdata[175:112]);
          check_field("out_name_16_19", want.name_hi, m_tdata[207:176]);
          check_field("position", want.position, m_tdata[212:208]);
          check_field("entries_held", want.held, m_tdata[217:213]);
          check_field("last", want.last, m_tlast);
        end
      end
      if (s_tvalid && s_tready) begin
        apply_table_op(cur_op);
        accepted_count++;
        op_taken = 1'b1;
      end
    end
  end

  task automatic add_op(input logic [KIND_W-1:0] kind, input logic signed [31:0] number,
                        input logic [15:0] score, input logic [63:0] name_lo,
                        input logic [63:0] name_mid, input logic [31:0] name_hi);
    table_op_t op;
    op.kind = kind;
    op.number = number;
    op.score = score;
    op.name_lo = name_lo;
    op.name_mid = name_mid;
    op.name_hi = name_hi;
    pending_ops.push_back(op);
    queued_count++;
  endtask

  // Random operations in bursts that lean toward filling the table, toward
  // draining it, or toward neither, so both the full and the empty table
  // come up often. Most keys come from a small pool so deletes hit.
  task automatic add_random_ops(input int unsigned count);
    int unsigned made;
    int unsigned ins_pct;
    int unsigned del_pct;
    int unsigned roll;
    logic [KIND_W-1:0] kind;
    logic signed [31:0] key;
    made = 0;
    ins_pct = 45;
    del_pct = 40;
    while (made < count) begin
      if (made % 20 == 0) begin
        case ($urandom_range(2))
          0: begin ins_pct = 75; del_pct = 15; end
          1: begin ins_pct = 15; del_pct = 75; end
          default: begin ins_pct = 45; del_pct = 40; end
        endcase
      end
      roll = $urandom_range(99);
      if (roll < 2) begin
        kind = KIND_UNUSED;
      end else if (roll < 2 + ins_pct) begin
        kind = KIND_INSERT;
      end else if (roll < 2 + ins_pct + del_pct) begin
        kind = KIND_DELETE;
      end else begin
        kind = KIND_DUMP;
      end
      if ($urandom_range(99) < 75) begin
        key = key_pool[$urandom_range(15)];
      end else begin
        key = $urandom();
      end
      add_op(kind, key, 16'($urandom_range(65535)), {$urandom(), $urandom()},
             {$urandom(), $urandom()}, $urandom());
      if (kind != KIND_UNUSED) begin
        made++;
      end
    end
  endtask

  // Waits until every operation is accepted and every result has come.
  task automatic wait_drained;
    while (accepted_count != queued_count || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (6) @(posedge clk_i);
  endtask

  initial begin
    key_pool[0] = 32'sh8000_0000;
    key_pool[1] = 32'sh8000_0001;
    key_pool[2] = -32'sd1;
    key_pool[3] = 32'sd0;
    key_pool[4] = 32'sd1;
    key_pool[5] = 32'sh7FFF_FFFE;
    key_pool[6] = 32'sh7FFF_FFFF;
    for (int i = 7; i < 16; i++) begin
      key_pool[i] = $urandom();
    end

    send_idle_pct = 21;
    recv_idle_pct = 87;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: empty table cases, head and tail insertion, equal keys,
    // the unused code, deleting the first of equal keys, the last node and a
    // missing key, then wiping the table down to a single entry and to none.
    add_op(KIND_DUMP, 32'sd0, 16'h0000, '0, '0, '0);
    add_op(KIND_DELETE, 32'sh8000_0000, 16'h0000, '0, '0, '0);
    add_op(KIND_INSERT, 32'sd0, 16'h0000, '0, '0, '0);
    add_op(KIND_INSERT, 32'sh8000_0000, 16'hFFFF, '1, '1, '1);
    add_op(KIND_INSERT, 32'sh7FFF_FFFF, 16'h1234, 64'h6867_6665_6463_6261,
           64'h706F_6E6D_6C6B_6A69, 32'h7473_7271);
    add_op(KIND_INSERT, 32'sd0, 16'h00A5, {$urandom(), $urandom()},
           {$urandom(), $urandom()}, $urandom());
    add_op(KIND_UNUSED, 32'sd0, 16'hFFFF, '1, '1, '1);
    add_op(KIND_DUMP, 32'sd0, 16'h0000, '0, '0, '0);
    add_op(KIND_DELETE, 32'sd0, 16'hFFFF, '1, '1, '1);
    add_op(KIND_DELETE, 32'sh7FFF_FFFF, 16'h0000, '0, '0, '0);
    add_op(KIND_DELETE, 32'sd7, 16'h0000, '0, '0, '0);
    add_op(KIND_DELETE, 32'sh8000_0000, 16'h0000, '0, '0, '0);
    add_op(KIND_DUMP, 32'sd0, 16'h0000, '0, '0, '0);
    add_op(KIND_DELETE, 32'sd0, 16'h0000, '0, '0, '0);
    add_op(KIND_DUMP, 32'sd0, 16'h0000, '0, '0, '0);
    add_op(KIND_INSERT, -32'sd1, 16'h8000, {$urandom(), $urandom()},
           {$urandom(), $urandom()}, $urandom());
    add_op(KIND_DELETE, -32'sd1, 16'h0000, '0, '0, '0);
    add_op(KIND_DUMP, 32'sd0, 16'h0000, '0, '0, '0);
    add_random_ops(120);
    // The sender stays quiet here until every expected result is back.
    wait_drained();

    send_idle_pct = 87;
    recv_idle_pct = 21;
    add_random_ops(120);
    wait_drained();

    // No idling. The receiver first holds off long enough for the block to
    // fill its output and stall the slave side while operations keep coming.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 200;
    add_random_ops(120);
    wait_drained();

    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Guard against a hung run.
  initial begin
    #15_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
